>>> sv/lrs_pkg.sv
// Package for the line rasterizer: widths, types, codes and helper functions.
`timescale 1ns / 1ps

package lrs_pkg;

    // Coordinate space of the line endpoints.
    localparam int COORD_RANGE = 64;
    localparam int COORD_W     = $clog2(COORD_RANGE);

    // Panel geometry registers.
    localparam int DIM_W      = 7;
    localparam int TILE_W     = 5;
    localparam int DIM_MAX    = 64;
    localparam int TILE_MAX   = 16;
    localparam int DIM_RESET  = 8;
    localparam int TILE_RESET = 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = DIM_W;

    // Payload widths.
    localparam int CHAN_W  = 8;
    localparam int COLOR_W = 3 * CHAN_W;
    localparam int IDX_W   = 18;

    // Datapath widths.
    localparam int ERR_W    = COORD_W + 2;
    localparam int SPAN_W   = TILE_W + DIM_W;
    localparam int AREA_W   = 2 * DIM_W;
    localparam int PROW_W   = COORD_W + TILE_W;
    localparam int PANEL_W  = PROW_W + 1;
    localparam int ROWOFF_W = COORD_W + DIM_W;
    localparam int PROD_W   = PANEL_W + AREA_W + 1;

    // Restoring division of the start point: one quotient bit per step.
    localparam int DIV_STEPS = COORD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    typedef logic [COORD_W-1:0]      coord_t;
    typedef logic [DIM_W-1:0]        dim_t;
    typedef logic [DIM_W:0]          dimx_t;
    typedef logic [TILE_W-1:0]       tile_t;
    typedef logic [CFG_DATA_W-1:0]   cfg_data_t;
    typedef logic [CHAN_W-1:0]       chan_t;
    typedef logic [COLOR_W-1:0]      color_t;
    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic signed [ERR_W-1:0] err_t;
    typedef logic [SPAN_W-1:0]       span_t;
    typedef logic [AREA_W-1:0]       area_t;
    typedef logic [PROW_W-1:0]       prow_t;
    typedef logic [PANEL_W-1:0]      panel_t;
    typedef logic [ROWOFF_W-1:0]     rowoff_t;
    typedef logic [PROD_W-1:0]       prod_t;
    typedef logic [CNT_W-1:0]        cnt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PANEL_WIDTH   = CFG_IDX_W'(0),
        CFG_PANEL_HEIGHT  = CFG_IDX_W'(1),
        CFG_PANELS_ACROSS = CFG_IDX_W'(2),
        CFG_PANELS_DOWN   = CFG_IDX_W'(3)
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WALK,
        ST_DRAIN
    } state_t;

    // Position along one axis split into panel-local offset and panel number.
    typedef struct packed {
        coord_t loc;
        coord_t tile;
    } track_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic div_step;
        logic walk;
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic advance;
        logic walk_last;
        logic pipe_empty;
    } dp_status_t;

    // Hold a panel dimension to 1..DIM_MAX.
    function automatic dim_t clamp_dim(input cfg_data_t v);
        dim_t r;
        if (v == '0)
            r = dim_t'(1);
        else if (dim_t'(v) > dim_t'(DIM_MAX))
            r = dim_t'(DIM_MAX);
        else
            r = dim_t'(v);
        return r;
    endfunction

    // Hold a panel count to 1..TILE_MAX.
    function automatic tile_t clamp_tiles(input tile_t v);
        tile_t r;
        if (v == '0)
            r = tile_t'(1);
        else if (v > tile_t'(TILE_MAX))
            r = tile_t'(TILE_MAX);
        else
            r = v;
        return r;
    endfunction

endpackage

>>> sv/lrs_if.sv
// Channel interfaces: line command in, pixel out, configuration write.
`timescale 1ns / 1ps

interface lrs_cmd_if;
    logic                  valid;
    logic                  ready;
    logic [lrs_pkg::COORD_W-1:0] x_start;
    logic [lrs_pkg::COORD_W-1:0] y_start;
    logic [lrs_pkg::COORD_W-1:0] x_end;
    logic [lrs_pkg::COORD_W-1:0] y_end;
    logic [lrs_pkg::CHAN_W-1:0]  red;
    logic [lrs_pkg::CHAN_W-1:0]  green;
    logic [lrs_pkg::CHAN_W-1:0]  blue;

    modport source (
        output valid, x_start, y_start, x_end, y_end, red, green, blue,
        input  ready
    );
    modport sink (
        input  valid, x_start, y_start, x_end, y_end, red, green, blue,
        output ready
    );
endinterface

interface lrs_pix_if;
    logic                        valid;
    logic                        ready;
    logic [lrs_pkg::COORD_W-1:0] pixel_x;
    logic [lrs_pkg::COORD_W-1:0] pixel_y;
    logic [lrs_pkg::IDX_W-1:0]   led_index;
    logic [lrs_pkg::COLOR_W-1:0] color_word;
    logic                        in_bounds;
    logic                        last;

    modport source (
        output valid, pixel_x, pixel_y, led_index, color_word, in_bounds, last,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, led_index, color_word, in_bounds, last,
        output ready
    );
endinterface

interface lrs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [lrs_pkg::CFG_IDX_W-1:0]  index;
    logic [lrs_pkg::CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

>>> sv/lrs_ctrl.sv
// Sequencer for the line rasterizer: load, divide, walk, drain.
`timescale 1ns / 1ps

module lrs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  lrs_pkg::dp_status_t sts,
    output lrs_pkg::dp_cmd_t    ctl
);

    lrs_pkg::state_t state_reg;
    lrs_pkg::state_t state_next;
    lrs_pkg::cnt_t   cnt_reg;
    lrs_pkg::cnt_t   cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lrs_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lrs_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                    state_next = lrs_pkg::ST_DIV;
            end
            lrs_pkg::ST_DIV:
            begin
                if (cnt_reg == lrs_pkg::cnt_t'(lrs_pkg::DIV_STEPS - 1))
                    state_next = lrs_pkg::ST_WALK;
            end
            lrs_pkg::ST_WALK:
            begin
                if (sts.advance && sts.walk_last)
                    state_next = lrs_pkg::ST_DRAIN;
            end
            lrs_pkg::ST_DRAIN:
            begin
                if (sts.pipe_empty)
                    state_next = lrs_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lrs_pkg::ST_IDLE;
            end
        endcase
    end

    // Count division steps; rest at zero elsewhere.
    always_comb
    begin
        if (state_reg == lrs_pkg::ST_DIV)
            cnt_next = cnt_reg + lrs_pkg::cnt_t'(1);
        else
            cnt_next = '0;
    end

    always_comb
    begin
        cmd_ready    = 1'b0;
        ctl.load     = 1'b0;
        ctl.div_step = 1'b0;
        ctl.walk     = 1'b0;
        case (state_reg)
            lrs_pkg::ST_IDLE:
            begin
                cmd_ready = 1'b1;
                ctl.load  = cmd_valid;
            end
            lrs_pkg::ST_DIV:
            begin
                ctl.div_step = 1'b1;
            end
            lrs_pkg::ST_WALK:
            begin
                ctl.walk = 1'b1;
            end
            lrs_pkg::ST_DRAIN:
            begin
                ctl.walk = 1'b0;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> sv/lrs_datapath.sv
// Datapath: geometry registers, Bresenham walker, panel tracking, strip index pipeline.
`timescale 1ns / 1ps

module lrs_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  lrs_pkg::dp_cmd_t    ctl,
    output lrs_pkg::dp_status_t sts,
    input  lrs_pkg::coord_t     x_start,
    input  lrs_pkg::coord_t     y_start,
    input  lrs_pkg::coord_t     x_end,
    input  lrs_pkg::coord_t     y_end,
    input  lrs_pkg::chan_t      red,
    input  lrs_pkg::chan_t      green,
    input  lrs_pkg::chan_t      blue,
    lrs_cfg_if.sink             cfg,
    lrs_pix_if.source           pix
);

    // One restoring-division step: shift in a dividend bit, subtract if it fits.
    function automatic lrs_pkg::track_t div_shift(
        input lrs_pkg::track_t t,
        input lrs_pkg::dim_t   size,
        input logic            bit_in
    );
        lrs_pkg::track_t res;
        lrs_pkg::dimx_t  r;
        logic            fit;
        r        = lrs_pkg::dimx_t'({t.loc, bit_in});
        fit      = r >= lrs_pkg::dimx_t'(size);
        res.loc  = fit ? lrs_pkg::coord_t'(r - lrs_pkg::dimx_t'(size))
                       : lrs_pkg::coord_t'(r);
        res.tile = lrs_pkg::coord_t'({t.tile, fit});
        return res;
    endfunction

    // Move one pixel along an axis, carrying across panel edges.
    function automatic lrs_pkg::track_t track_step(
        input lrs_pkg::track_t t,
        input lrs_pkg::dim_t   size,
        input logic            inc,
        input logic            dec
    );
        lrs_pkg::track_t res;
        res = t;
        if (inc)
        begin
            if (lrs_pkg::dim_t'(t.loc) == size - lrs_pkg::dim_t'(1))
            begin
                res.loc  = '0;
                res.tile = t.tile + lrs_pkg::coord_t'(1);
            end
            else
                res.loc = t.loc + lrs_pkg::coord_t'(1);
        end
        else if (dec)
        begin
            if (t.loc == '0)
            begin
                res.loc  = lrs_pkg::coord_t'(size - lrs_pkg::dim_t'(1));
                res.tile = t.tile - lrs_pkg::coord_t'(1);
            end
            else
                res.loc = t.loc - lrs_pkg::coord_t'(1);
        end
        return res;
    endfunction

    // ---------------- geometry registers ----------------
    lrs_pkg::dim_t  pw_reg;
    lrs_pkg::dim_t  ph_reg;
    lrs_pkg::tile_t pa_reg;
    lrs_pkg::tile_t pd_reg;
    lrs_pkg::span_t span_x_reg;
    lrs_pkg::span_t span_y_reg;
    lrs_pkg::area_t area_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_reg <= lrs_pkg::dim_t'(lrs_pkg::DIM_RESET);
            ph_reg <= lrs_pkg::dim_t'(lrs_pkg::DIM_RESET);
            pa_reg <= lrs_pkg::tile_t'(lrs_pkg::TILE_RESET);
            pd_reg <= lrs_pkg::tile_t'(lrs_pkg::TILE_RESET);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                lrs_pkg::CFG_PANEL_WIDTH:
                    pw_reg <= lrs_pkg::clamp_dim(cfg.data);
                lrs_pkg::CFG_PANEL_HEIGHT:
                    ph_reg <= lrs_pkg::clamp_dim(cfg.data);
                lrs_pkg::CFG_PANELS_ACROSS:
                    pa_reg <= lrs_pkg::clamp_tiles(lrs_pkg::tile_t'(cfg.data));
                lrs_pkg::CFG_PANELS_DOWN:
                    pd_reg <= lrs_pkg::clamp_tiles(lrs_pkg::tile_t'(cfg.data));
                default:
                    pw_reg <= pw_reg;
            endcase
        end
    end

    // Area products follow the registers; they settle while the block is idle.
    always_ff @(posedge clk)
    begin
        span_x_reg <= lrs_pkg::span_t'(pa_reg) * lrs_pkg::span_t'(pw_reg);
        span_y_reg <= lrs_pkg::span_t'(pd_reg) * lrs_pkg::span_t'(ph_reg);
        area_reg   <= lrs_pkg::area_t'(pw_reg) * lrs_pkg::area_t'(ph_reg);
    end

    // ---------------- command set-up ----------------
    lrs_pkg::coord_t adx;
    lrs_pkg::coord_t ady;
    lrs_pkg::coord_t a0;
    lrs_pkg::coord_t b0;
    lrs_pkg::coord_t a1;
    lrs_pkg::coord_t b1;
    lrs_pkg::coord_t maj0;
    lrs_pkg::coord_t min0;
    lrs_pkg::coord_t maj1;
    lrs_pkg::coord_t min1;
    logic            steep_ld;
    logic            swap_ld;

    always_comb
    begin
        adx      = (x_end > x_start) ? x_end - x_start : x_start - x_end;
        ady      = (y_end > y_start) ? y_end - y_start : y_start - y_end;
        steep_ld = ady > adx;
        a0       = steep_ld ? y_start : x_start;
        b0       = steep_ld ? x_start : y_start;
        a1       = steep_ld ? y_end : x_end;
        b1       = steep_ld ? x_end : y_end;
        swap_ld  = a0 > a1;
        maj0     = swap_ld ? a1 : a0;
        min0     = swap_ld ? b1 : b0;
        maj1     = swap_ld ? a0 : a1;
        min1     = swap_ld ? b0 : b1;
    end

    // ---------------- walker ----------------
    lrs_pkg::coord_t maj_reg;
    lrs_pkg::coord_t maj_end_reg;
    lrs_pkg::coord_t min_reg;
    lrs_pkg::coord_t dx_reg;
    lrs_pkg::coord_t dy_reg;
    lrs_pkg::err_t   err_reg;
    logic            steep_reg;
    logic            neg_reg;
    lrs_pkg::color_t color_reg;
    lrs_pkg::coord_t dvx_reg;
    lrs_pkg::coord_t dvy_reg;
    lrs_pkg::track_t trx_reg;
    lrs_pkg::track_t try_reg;

    lrs_pkg::err_t   err_sub;
    lrs_pkg::err_t   err_walk;
    logic            minor_move;
    logic            advance;
    logic            walk_fire;
    logic            walk_last;
    lrs_pkg::coord_t px;
    lrs_pkg::coord_t py;

    logic            out_valid_reg;

    assign advance   = !out_valid_reg || pix.ready;
    assign walk_fire = ctl.walk && advance;
    assign walk_last = maj_reg == maj_end_reg;
    assign px        = steep_reg ? min_reg : maj_reg;
    assign py        = steep_reg ? maj_reg : min_reg;

    always_comb
    begin
        err_sub    = err_reg - lrs_pkg::err_t'(dy_reg);
        minor_move = err_sub[lrs_pkg::ERR_W-1];
        err_walk   = minor_move ? err_sub + lrs_pkg::err_t'(dx_reg) : err_sub;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            maj_reg     <= maj0;
            maj_end_reg <= maj1;
            min_reg     <= min0;
            dx_reg      <= maj1 - maj0;
            dy_reg      <= (min1 > min0) ? min1 - min0 : min0 - min1;
            err_reg     <= lrs_pkg::err_t'((maj1 - maj0) >> 1);
            steep_reg   <= steep_ld;
            neg_reg     <= !(min0 < min1);
            color_reg   <= {red, green, blue};
            dvx_reg     <= steep_ld ? min0 : maj0;
            dvy_reg     <= steep_ld ? maj0 : min0;
            trx_reg     <= '0;
            try_reg     <= '0;
        end
        else if (ctl.div_step)
        begin
            trx_reg <= div_shift(trx_reg, pw_reg, dvx_reg[lrs_pkg::COORD_W-1]);
            try_reg <= div_shift(try_reg, ph_reg, dvy_reg[lrs_pkg::COORD_W-1]);
            dvx_reg <= dvx_reg << 1;
            dvy_reg <= dvy_reg << 1;
        end
        else if (walk_fire)
        begin
            maj_reg <= maj_reg + lrs_pkg::coord_t'(1);
            if (minor_move)
                min_reg <= neg_reg ? min_reg - lrs_pkg::coord_t'(1)
                                   : min_reg + lrs_pkg::coord_t'(1);
            err_reg <= err_walk;
            trx_reg <= track_step(trx_reg, pw_reg,
                                  !steep_reg || (minor_move && !neg_reg),
                                  steep_reg && minor_move && neg_reg);
            try_reg <= track_step(try_reg, ph_reg,
                                  steep_reg || (minor_move && !neg_reg),
                                  !steep_reg && minor_move && neg_reg);
        end
    end

    // ---------------- stage 1: row terms ----------------
    logic             s1_valid_reg;
    lrs_pkg::coord_t  s1_px_reg;
    lrs_pkg::coord_t  s1_py_reg;
    lrs_pkg::coord_t  s1_pcol_reg;
    lrs_pkg::prow_t   s1_prowpa_reg;
    lrs_pkg::rowoff_t s1_rowoff_reg;
    lrs_pkg::coord_t  s1_col_reg;
    logic             s1_inb_reg;
    logic             s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (advance)
            s1_valid_reg <= walk_fire;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_px_reg     <= px;
            s1_py_reg     <= py;
            s1_pcol_reg   <= trx_reg.tile;
            s1_prowpa_reg <= lrs_pkg::prow_t'(try_reg.tile) * lrs_pkg::prow_t'(pa_reg);
            s1_rowoff_reg <= lrs_pkg::rowoff_t'(try_reg.loc) * lrs_pkg::rowoff_t'(pw_reg);
            s1_col_reg    <= try_reg.loc[0]
                           ? lrs_pkg::coord_t'(pw_reg - lrs_pkg::dim_t'(1)
                                               - lrs_pkg::dim_t'(trx_reg.loc))
                           : trx_reg.loc;
            s1_inb_reg    <= (lrs_pkg::span_t'(px) < span_x_reg)
                          && (lrs_pkg::span_t'(py) < span_y_reg);
            s1_last_reg   <= walk_last;
        end
    end

    // ---------------- stage 2: strip index, output register ----------------
    lrs_pkg::coord_t out_px_reg;
    lrs_pkg::coord_t out_py_reg;
    lrs_pkg::idx_t   out_idx_reg;
    logic            out_inb_reg;
    logic            out_last_reg;
    lrs_pkg::panel_t panel;
    lrs_pkg::prod_t  idx_sum;

    always_comb
    begin
        panel   = lrs_pkg::panel_t'(s1_pcol_reg) + lrs_pkg::panel_t'(s1_prowpa_reg);
        idx_sum = lrs_pkg::prod_t'(panel) * lrs_pkg::prod_t'(area_reg)
                + lrs_pkg::prod_t'(s1_rowoff_reg)
                + lrs_pkg::prod_t'(s1_col_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_px_reg   <= s1_px_reg;
            out_py_reg   <= s1_py_reg;
            out_idx_reg  <= s1_inb_reg ? lrs_pkg::idx_t'(idx_sum) : '0;
            out_inb_reg  <= s1_inb_reg;
            out_last_reg <= s1_last_reg;
        end
    end

    assign pix.valid      = out_valid_reg;
    assign pix.pixel_x    = out_px_reg;
    assign pix.pixel_y    = out_py_reg;
    assign pix.led_index  = out_idx_reg;
    assign pix.color_word = color_reg;
    assign pix.in_bounds  = out_inb_reg;
    assign pix.last       = out_last_reg;

    assign sts.advance    = advance;
    assign sts.walk_last  = walk_last;
    assign sts.pipe_empty = !s1_valid_reg && !out_valid_reg;

    // Panel-local offsets stay inside the panel while walking.
    a_loc_in_panel: assert property (@(posedge clk) disable iff (!rst_n)
        walk_fire |-> (lrs_pkg::dim_t'(trx_reg.loc) < pw_reg)
                   && (lrs_pkg::dim_t'(try_reg.loc) < ph_reg))
        else $error("panel-local offset out of range");

    // The walker never steps past the far endpoint.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        walk_fire |-> maj_reg <= maj_end_reg)
        else $error("walker overran line end");

    // Off-panel pixels carry a zero strip index.
    a_off_panel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_inb_reg) |-> out_idx_reg == '0)
        else $error("off-panel pixel with nonzero index");

endmodule

>>> sv/line_rasterizer_serpentine.sv
// Top level of the line rasterizer with serpentine LED-strip addressing.
// Throughput: a line of N pixels (N = major-axis length + 1, at most 64) streams one
// pixel per cycle while the pixel side does not stall; the next command is taken only
// once the previous line has drained from the pipeline. Set-up is a 6-step restoring
// division of the start point.
// Reset: asynchronous, active low; geometry returns to one 8x8 panel, block goes idle.
`timescale 1ns / 1ps

module line_rasterizer_serpentine (
    input  logic      clk,
    input  logic      rst_n,
    lrs_cmd_if.sink   cmd,
    lrs_pix_if.source pix,
    lrs_cfg_if.sink   cfg
);

    // Command and status between the sequencer and the datapath.
    lrs_pkg::dp_cmd_t    ctl;
    lrs_pkg::dp_status_t sts;
    logic                cmd_ready;

    // Take a line command only while idle; one line is in flight at a time.
    assign cmd.ready = cmd_ready;

    // Sequencer: idle -> divide start point into panel/offset -> walk -> drain.
    lrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    // Datapath: hold the geometry registers, walk the line with the Bresenham
    // error term, track panel column/row and in-panel offsets incrementally, and
    // form the strip index in a two-stage pipeline whose second stage is the output register.
    // The whole pipeline holds while a pixel transaction is stalled.
    lrs_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .sts     (sts),
        .x_start (cmd.x_start),
        .y_start (cmd.y_start),
        .x_end   (cmd.x_end),
        .y_end   (cmd.y_end),
        .red     (cmd.red),
        .green   (cmd.green),
        .blue    (cmd.blue),
        .cfg     (cfg),
        .pix     (pix)
    );

endmodule

>>> sim/tb_line_rasterizer_serpentine.sv
// Testbench for the line rasterizer: line commands under panel geometry sweeps, pixels checked in order.
`timescale 1ns / 1ps

module tb_line_rasterizer_serpentine;

    import lrs_pkg::*;

    // Percentage of cycles in which a side holds off.
    localparam int IDLE_PCT      = 24;
    // Cycles to let pass once the last pixel is in, before touching the geometry.
    localparam int SETTLE_CYCLES = 20;
    // Generous bound on the whole run: about 330 lines, up to 64 pixels each,
    // stalls on both sides and the geometry phases, taken several times over.
    localparam int CYCLE_LIMIT   = 400000;
    // Keep the log short if the block goes badly wrong.
    localparam int MAX_REPORTS   = 100;
    // First register index with no register behind it.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = CFG_IDX_W'(4);
    localparam int CFG_INDEX_TOP = (1 << CFG_IDX_W) - 1;

    typedef struct packed {
        coord_t x_start;
        coord_t y_start;
        coord_t x_end;
        coord_t y_end;
        chan_t  red;
        chan_t  green;
        chan_t  blue;
    } line_cmd_t;

    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        idx_t   led_index;
        color_t color_word;
        logic   in_bounds;
        logic   last;
    } pixel_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        cfg_data_t            data;
    } geom_write_t;

    logic clk = 1'b0;
    logic rst_n;

    lrs_cmd_if cmd_ch ();
    lrs_pix_if pix_ch ();
    lrs_cfg_if cfg_ch ();

    line_rasterizer_serpentine dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch.sink),
        .pix   (pix_ch.source),
        .cfg   (cfg_ch.sink)
    );

    // Free-running clock, 10 ns period.
    always #5 clk = ~clk;

    // Everything the testbench drives comes from these, so every input is
    // known from time zero.
    logic        cmd_valid  = 1'b0;
    line_cmd_t   cmd_shown  = '0;
    logic        cfg_valid  = 1'b0;
    geom_write_t cfg_shown  = '0;
    logic        pix_ready  = 1'b0;

    assign cmd_ch.valid = cmd_valid;
    assign {cmd_ch.x_start, cmd_ch.y_start, cmd_ch.x_end, cmd_ch.y_end,
            cmd_ch.red, cmd_ch.green, cmd_ch.blue} = cmd_shown;
    assign cfg_ch.valid = cfg_valid;
    assign {cfg_ch.index, cfg_ch.data} = cfg_shown;
    assign pix_ch.ready = pix_ready;

    // Pending line commands, pending register writes, and pixels still owed.
    line_cmd_t   line_backlog[$];
    geom_write_t geom_writes[$];
    pixel_t      pixel_expect_q[$];

    // Shadow copy of the geometry registers, raw as written.
    dim_t  width_reg  = dim_t'(DIM_RESET);
    dim_t  height_reg = dim_t'(DIM_RESET);
    tile_t across_reg = tile_t'(TILE_RESET);
    tile_t down_reg   = tile_t'(TILE_RESET);

    // When set, neither side idles.
    logic steady = 1'b0;

    int fail_count  = 0;
    int cycle_count = 0;

    pixel_t seen_pixel;
    pixel_t want_pixel;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Read a register value the way the block does: 0 counts as 1, and
    // anything above the maximum counts as the maximum.
    function automatic int hold_range(input int v, input int hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    // Work out whether a pixel lands on the panels and where on the strip.
    // Panels are numbered row by row; inside a panel odd rows run backward.
    function automatic void strip_position(input int x, input int y,
                                           output logic inb, output idx_t led);
        int pw, ph, pa, pd, lx, ly, col;
        pw  = hold_range(width_reg, DIM_MAX);
        ph  = hold_range(height_reg, DIM_MAX);
        pa  = hold_range(across_reg, TILE_MAX);
        pd  = hold_range(down_reg, TILE_MAX);
        inb = (x < pa * pw) && (y < pd * ph);
        led = '0;
        if (inb)
        begin
            lx  = x % pw;
            ly  = y % ph;
            col = (ly % 2 == 1) ? (pw - lx - 1) : lx;
            led = idx_t'(((x / pw) + (y / ph) * pa) * pw * ph + ly * pw + col);
        end
    endfunction

    // Walk one line with the integer error method and queue every pixel it
    // produces, from the low end of the major axis to the high end.
    function automatic void trace_line(input line_cmd_t c);
        int     x0, y0, x1, y1, t, adx, ady, dx, dy, err, ystep, x, y;
        logic   steep;
        pixel_t p;
        x0    = c.x_start;
        y0    = c.y_start;
        x1    = c.x_end;
        y1    = c.y_end;
        adx   = (x1 > x0) ? x1 - x0 : x0 - x1;
        ady   = (y1 > y0) ? y1 - y0 : y0 - y1;
        steep = ady > adx;
        if (steep)
        begin
            t = x0; x0 = y0; y0 = t;
            t = x1; x1 = y1; y1 = t;
        end
        if (x0 > x1)
        begin
            t = x0; x0 = x1; x1 = t;
            t = y0; y0 = y1; y1 = t;
        end
        dx    = x1 - x0;
        dy    = (y1 > y0) ? y1 - y0 : y0 - y1;
        err   = dx / 2;
        ystep = (y0 < y1) ? 1 : -1;
        y     = y0;
        for (x = x0; x <= x1; x++)
        begin
            p.pixel_x    = coord_t'(steep ? y : x);
            p.pixel_y    = coord_t'(steep ? x : y);
            strip_position(steep ? y : x, steep ? x : y, p.in_bounds, p.led_index);
            p.color_word = {c.red, c.green, c.blue};
            p.last       = (x == x1);
            pixel_expect_q.push_back(p);
            err -= dy;
            if (err < 0)
            begin
                y   += ystep;
                err += dx;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Command driver
    // ------------------------------------------------------------------

    // Hold a command until the block takes it; predict its pixels at the
    // transaction, then offer the next one or stay idle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
        end
        else if (!cmd_valid || cmd_ch.ready)
        begin
            if (cmd_valid)
                trace_line(cmd_shown);
            if (line_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
            begin
                cmd_valid <= 1'b1;
                cmd_shown <= line_backlog.pop_front();
            end
            else
            begin
                cmd_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Geometry register driver
    // ------------------------------------------------------------------

    // Same pattern as the command side; at each transaction update the
    // shadow registers. Writes to an unmapped index change nothing.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
        end
        else if (!cfg_valid || cfg_ch.ready)
        begin
            if (cfg_valid)
            begin
                case (cfg_shown.index)
                    CFG_PANEL_WIDTH:   width_reg  = dim_t'(cfg_shown.data);
                    CFG_PANEL_HEIGHT:  height_reg = dim_t'(cfg_shown.data);
                    CFG_PANELS_ACROSS: across_reg = tile_t'(cfg_shown.data);
                    CFG_PANELS_DOWN:   down_reg   = tile_t'(cfg_shown.data);
                    default: ;
                endcase
            end
            if (geom_writes.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
            begin
                cfg_valid <= 1'b1;
                cfg_shown <= geom_writes.pop_front();
            end
            else
            begin
                cfg_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Pixel monitor
    // ------------------------------------------------------------------

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            if (fail_count < MAX_REPORTS)
                $error("pixel field %s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Compare every pixel transaction with the oldest pixel still owed,
    // and stall the pixel side at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_ready <= 1'b0;
        end
        else
        begin
            if (pix_ch.valid && pix_ready)
            begin
                seen_pixel = {pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.led_index,
                              pix_ch.color_word, pix_ch.in_bounds, pix_ch.last};
                if (pixel_expect_q.size() == 0)
                begin
                    if (fail_count < MAX_REPORTS)
                        $error("pixel transaction with no pixel owed: x=%0d y=%0d",
                               seen_pixel.pixel_x, seen_pixel.pixel_y);
                    fail_count++;
                end
                else
                begin
                    want_pixel = pixel_expect_q.pop_front();
                    compare_field("pixel_x", want_pixel.pixel_x, seen_pixel.pixel_x);
                    compare_field("pixel_y", want_pixel.pixel_y, seen_pixel.pixel_y);
                    compare_field("led_index", want_pixel.led_index, seen_pixel.led_index);
                    compare_field("color_word", want_pixel.color_word,
                                  seen_pixel.color_word);
                    compare_field("in_bounds", want_pixel.in_bounds, seen_pixel.in_bounds);
                    compare_field("last", want_pixel.last, seen_pixel.last);
                end
            end
            pix_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic queue_line(input int xs, input int ys, input int xe, input int ye,
                              input int r, input int g, input int b);
        line_cmd_t c;
        c.x_start = coord_t'(xs);
        c.y_start = coord_t'(ys);
        c.x_end   = coord_t'(xe);
        c.y_end   = coord_t'(ye);
        c.red     = chan_t'(r);
        c.green   = chan_t'(g);
        c.blue    = chan_t'(b);
        line_backlog.push_back(c);
    endtask

    // Wait until every command is taken and every pixel is in, then let the
    // block run out its pipeline. Check on the falling edge, once the drivers
    // have settled their rising-edge updates.
    task automatic settle();
        while (line_backlog.size() != 0 || cmd_valid || pixel_expect_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all four geometry registers, plus one write to an unmapped index,
    // with the block idle.
    task automatic set_geometry(input cfg_data_t w, input cfg_data_t h,
                                input cfg_data_t a, input cfg_data_t d);
        geom_write_t wr;
        settle();
        wr.index = CFG_PANEL_WIDTH;   wr.data = w; geom_writes.push_back(wr);
        wr.index = CFG_IDX_W'($urandom_range(CFG_UNMAPPED, CFG_INDEX_TOP));
        wr.data  = cfg_data_t'($urandom);
        geom_writes.push_back(wr);
        wr.index = CFG_PANEL_HEIGHT;  wr.data = h; geom_writes.push_back(wr);
        wr.index = CFG_PANELS_ACROSS; wr.data = a; geom_writes.push_back(wr);
        wr.index = CFG_PANELS_DOWN;   wr.data = d; geom_writes.push_back(wr);
        while (geom_writes.size() != 0 || cfg_valid)
            @(negedge clk);
    endtask

    // Mostly lines anywhere, with short lines, straight lines and single
    // points mixed in.
    task automatic random_lines(input int count);
        int k, kind, x0, y0, x1, y1;
        for (k = 0; k < count; k++)
        begin
            kind = $urandom_range(99);
            x0   = $urandom_range(63);
            y0   = $urandom_range(63);
            x1   = $urandom_range(63);
            y1   = $urandom_range(63);
            if (kind >= 55 && kind < 80)
            begin
                // short line around the start point
                x1 = x0 + int'($urandom_range(16)) - 8;
                y1 = y0 + int'($urandom_range(16)) - 8;
                if (x1 < 0)  x1 = 0;
                if (x1 > 63) x1 = 63;
                if (y1 < 0)  y1 = 0;
                if (y1 > 63) y1 = 63;
            end
            else if (kind >= 80 && kind < 90)
            begin
                // horizontal or vertical
                if (kind % 2 == 0)
                    y1 = y0;
                else
                    x1 = x0;
            end
            else if (kind >= 90)
            begin
                x1 = x0;
                y1 = y0;
            end
            queue_line(x0, y0, x1, y1,
                       $urandom_range(255), $urandom_range(255), $urandom_range(255));
        end
    endtask

    task automatic random_geometry();
        cfg_data_t w, h;
        w = ($urandom_range(99) < 70) ? cfg_data_t'($urandom_range(1, 16))
                                      : cfg_data_t'($urandom);
        h = ($urandom_range(99) < 70) ? cfg_data_t'($urandom_range(1, 16))
                                      : cfg_data_t'($urandom);
        set_geometry(w, h, cfg_data_t'($urandom), cfg_data_t'($urandom));
    endtask

    initial
    begin
        // Hold reset once, at the start.
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines on the reset geometry, one 8x8 panel, so most of
        // these also run off the panel area.
        queue_line(0, 0, 0, 0, 8'h00, 8'h00, 8'h00);      // single point at the origin
        queue_line(63, 63, 63, 63, 8'hff, 8'hff, 8'hff);  // single point at the far corner
        queue_line(0, 0, 63, 0, 8'hff, 8'h00, 8'h00);     // full-width horizontal
        queue_line(63, 5, 0, 5, 8'h00, 8'hff, 8'h00);     // horizontal, endpoints swapped
        queue_line(7, 0, 7, 63, 8'h00, 8'h00, 8'hff);     // full-height vertical
        queue_line(7, 63, 7, 0, 8'ha5, 8'h5a, 8'hc3);     // vertical, endpoints swapped
        queue_line(0, 0, 63, 63, 8'h55, 8'haa, 8'h55);    // main diagonal
        queue_line(63, 0, 0, 63, 8'haa, 8'h55, 8'haa);    // anti-diagonal
        queue_line(0, 0, 63, 20, 8'h01, 8'h80, 8'hfe);    // shallow rising
        queue_line(0, 40, 63, 0, 8'h7f, 8'h01, 8'h80);    // shallow falling
        queue_line(3, 0, 10, 63, 8'h12, 8'h34, 8'h56);    // steep
        queue_line(10, 63, 3, 0, 8'h65, 8'h43, 8'h21);    // steep, endpoints swapped
        queue_line(0, 0, 1, 0, 8'hff, 8'h00, 8'hff);      // two pixels
        queue_line(5, 5, 4, 6, 8'h00, 8'hff, 8'h00);      // one step both ways
        queue_line(0, 0, 2, 1, 8'h0f, 8'hf0, 8'h0f);      // half-step error start
        queue_line(6, 6, 9, 9, 8'hf0, 8'h0f, 8'hf0);      // across the panel edge
        queue_line(0, 1, 7, 1, 8'h3c, 8'hc3, 8'h3c);      // one reversed row, fully in
        random_lines(35);

        // Smallest geometry: a single pixel.
        set_geometry(cfg_data_t'(1), cfg_data_t'(1), cfg_data_t'(1), cfg_data_t'(1));
        queue_line(0, 0, 0, 0, 8'hff, 8'h00, 8'h00);
        queue_line(0, 0, 3, 0, 8'h00, 8'hff, 8'h00);
        random_lines(35);

        // Largest geometry: sixteen by sixteen 64x64 panels.
        set_geometry(cfg_data_t'(DIM_MAX), cfg_data_t'(DIM_MAX),
                     cfg_data_t'(TILE_MAX), cfg_data_t'(TILE_MAX));
        queue_line(0, 63, 63, 63, 8'hff, 8'hff, 8'h00);
        random_lines(35);

        // Zero everywhere reads as one.
        set_geometry('0, '0, '0, '0);
        random_lines(30);

        // All ones reads as the maximum.
        set_geometry('1, '1, '1, '1);
        random_lines(30);

        // Eight by eight tiles of 8x8 cover the whole coordinate space; run
        // this one without idling on either side.
        set_geometry(cfg_data_t'(8), cfg_data_t'(8), cfg_data_t'(8), cfg_data_t'(8));
        steady = 1'b1;
        random_lines(60);
        settle();
        steady = 1'b0;

        // Random geometries.
        repeat (3)
        begin
            random_geometry();
            random_lines(20);
        end

        // Back to the reset geometry.
        set_geometry(cfg_data_t'(DIM_RESET), cfg_data_t'(DIM_RESET),
                     cfg_data_t'(TILE_RESET), cfg_data_t'(TILE_RESET));
        random_lines(20);

        // Drain and report.
        settle();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
sv/lrs_pkg.sv
sv/lrs_if.sv
sv/lrs_ctrl.sv
sv/lrs_datapath.sv
sv/line_rasterizer_serpentine.sv
sim/tb_line_rasterizer_serpentine.sv
